/* rtl/c2ba_pkg.sv */
// shared types and constants for the 2x2 backward accumulate block
package c2ba_pkg;

   localparam int DATA_W    = 32;
   localparam int COLS_W    = 11;
   localparam int ROWS_W    = 16;
   localparam int PROD_W    = 48;
   localparam int SUM_W     = 51;
   localparam int CSR_IDX_W = 3;
   localparam int FRAC_W    = 16;

   localparam logic [CSR_IDX_W-1:0] CSR_WEIGHT_TL = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_WEIGHT_TR = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_WEIGHT_BL = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_WEIGHT_BR = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_COLUMNS   = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_ROWS      = 3'd5;

   typedef struct packed {
      logic signed [DATA_W-1:0] top_left;
      logic signed [DATA_W-1:0] top_right;
      logic signed [DATA_W-1:0] bottom_left;
      logic signed [DATA_W-1:0] bottom_right;
   } weights_type;

   // operands of one grid position, neighbours already masked
   typedef struct packed {
      logic signed [DATA_W-1:0] accum;
      logic signed [DATA_W-1:0] cur;
      logic signed [DATA_W-1:0] left;
      logic signed [DATA_W-1:0] up;
      logic signed [DATA_W-1:0] upper_left;
      logic                     done;
   } operands_type;

endpackage

/* rtl/c2ba_req_if.sv */
// input channel: accumulator value and source sample per grid position
interface c2ba_req_if import c2ba_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic signed [DATA_W-1:0] accum_in;
   logic signed [DATA_W-1:0] source_sample;

   modport source (output valid, output accum_in, output source_sample, input ready);
   modport sink (input valid, input accum_in, input source_sample, output ready);
endinterface

/* rtl/c2ba_rsp_if.sv */
// result channel: updated accumulator value and end of plane flag
interface c2ba_rsp_if import c2ba_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic signed [DATA_W-1:0] accum_out;
   logic                     plane_done;

   modport source (output valid, output accum_out, output plane_done, input ready);
   modport sink (input valid, input accum_out, input plane_done, output ready);
endinterface

/* rtl/c2ba_line_store.sv */
// line store holding the previous source row, cleared by a sweep after reset
module c2ba_line_store import c2ba_pkg::*; #(
   parameter int MAX_COLUMNS = 1024,
   localparam int AW = $clog2(MAX_COLUMNS)
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              wr_en,
   input  logic [AW-1:0]     wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic              rd_en,
   input  logic [AW-1:0]     rd_addr,
   output logic [DATA_W-1:0] rd_data,
   output logic              clear_busy
);

   logic [DATA_W-1:0] mem [MAX_COLUMNS];
   logic [DATA_W-1:0] rd_data_ff;
   logic              clr_busy_ff;
   logic [AW-1:0]     clr_addr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_busy_ff <= 1'b1;
         clr_addr_ff <= '0;
      end else if (clr_busy_ff) begin
         if (clr_addr_ff == AW'(MAX_COLUMNS - 1)) begin
            clr_busy_ff <= 1'b0;
         end
         clr_addr_ff <= clr_addr_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (clr_busy_ff) begin
         mem[clr_addr_ff] <= '0;
      end else if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data    = rd_data_ff;
   assign clear_busy = clr_busy_ff;

endmodule

/* rtl/c2ba_mac.sv */
// four weighted products, accumulate and saturate, with the result register
module c2ba_mac import c2ba_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  weights_type  weights,
   input  operands_type op,
   input  logic         op_valid,
   output logic         op_ready,
   c2ba_rsp_if.source   rsp
);

   logic                     p_valid_ff;
   logic signed [PROD_W-1:0] p0_ff, p1_ff, p2_ff, p3_ff;
   logic signed [DATA_W-1:0] p_accum_ff;
   logic                     p_done_ff;

   logic                     out_valid_ff;
   logic signed [DATA_W-1:0] out_accum_ff;
   logic                     out_done_ff;

   logic signed [2*DATA_W-1:0] m0, m1, m2, m3;
   logic signed [SUM_W-1:0]    sum;
   logic signed [DATA_W-1:0]   sat;
   logic                       p_ready;
   logic                       p_adv;
   logic                       op_adv;

   assign p_ready  = !out_valid_ff || rsp.ready;
   assign op_ready = !p_valid_ff || p_ready;
   assign op_adv   = op_valid && op_ready;
   assign p_adv    = p_valid_ff && p_ready;

   always_comb begin
      m0 = 64'(op.cur)        * 64'(weights.top_left);
      m1 = 64'(op.left)       * 64'(weights.top_right);
      m2 = 64'(op.up)         * 64'(weights.bottom_left);
      m3 = 64'(op.upper_left) * 64'(weights.bottom_right);
   end

   always_comb begin
      sum = SUM_W'(p_accum_ff) + SUM_W'(p0_ff) + SUM_W'(p1_ff)
          + SUM_W'(p2_ff) + SUM_W'(p3_ff);
      // fits when all bits above the sign bit agree with it
      if (sum[SUM_W-1:DATA_W-1] == '0 || sum[SUM_W-1:DATA_W-1] == '1) begin
         sat = sum[DATA_W-1:0];
      end else if (sum[SUM_W-1]) begin
         sat = {1'b1, {(DATA_W-1){1'b0}}};
      end else begin
         sat = {1'b0, {(DATA_W-1){1'b1}}};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p_valid_ff   <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (op_ready) begin
            p_valid_ff <= op_valid;
         end
         if (p_ready) begin
            out_valid_ff <= p_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (op_adv) begin
         // products floor-shifted back to q32.16
         p0_ff      <= m0[2*DATA_W-1:FRAC_W];
         p1_ff      <= m1[2*DATA_W-1:FRAC_W];
         p2_ff      <= m2[2*DATA_W-1:FRAC_W];
         p3_ff      <= m3[2*DATA_W-1:FRAC_W];
         p_accum_ff <= op.accum;
         p_done_ff  <= op.done;
      end
      if (p_adv) begin
         out_accum_ff <= sat;
         out_done_ff  <= p_done_ff;
      end
   end

   assign rsp.valid      = out_valid_ff;
   assign rsp.accum_out  = out_accum_ff;
   assign rsp.plane_done = out_done_ff;

endmodule

/* rtl/conv2x2_backward_accumulate.sv */
// top level: raster position tracking, neighbour registers and line store access
//
// Streams a (rows+1) x (columns+1) accumulator grid in raster order and adds
// the 2x2 transposed convolution of the source plane into it. Each req beat
// carries accum_in and source_sample for one grid position; each rsp beat
// returns accum_out and plane_done, set on the last position of the plane.
// Weights and plane size must be written through the csr port while no beat
// is in flight; the block itself does not enforce this. Position counters
// continue across such writes. One beat is taken every cycle while rsp does
// not stall and no line store sweep is running. A beat reaches rsp through
// three register stages: the input stage (with the line store read), the
// product registers of the four 32x32 multipliers, and the saturated result
// register. When rsp stalls, beats fill the three stages and then
// req_bus.ready drops; no beat is lost or duplicated.
// After reset the line store is swept to zero one entry per cycle;
// req_bus.ready stays low meanwhile, csr writes are taken as usual.
module conv2x2_backward_accumulate import c2ba_pkg::*; #(
   parameter int MAX_COLUMNS = 1024
) (
   input  logic                 clock,
   input  logic                 reset,
   c2ba_req_if.sink             req_bus,
   c2ba_rsp_if.source           rsp_bus,
   input  logic                 csr_write_enable,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [DATA_W-1:0]    csr_write_data
);

   localparam int AW = $clog2(MAX_COLUMNS);
   localparam int CW = $clog2(MAX_COLUMNS + 1);

   weights_type        weights_ff;
   logic [COLS_W-1:0]  columns_ff;
   logic [ROWS_W-1:0]  rows_ff;

   logic [CW-1:0]      col_count_ff;
   logic [ROWS_W-1:0]  row_count_ff;
   logic [DATA_W-1:0]  left_ff;
   logic [DATA_W-1:0]  upper_left_ff;

   logic               s1_valid_ff;
   logic [DATA_W-1:0]  s1_accum_ff;
   logic [DATA_W-1:0]  s1_cur_ff;
   logic [DATA_W-1:0]  s1_left_ff;
   logic               s1_up_en_ff;
   logic               s1_ul_en_ff;
   logic               s1_done_ff;

   logic [CW-1:0]      cols_eff;
   logic [ROWS_W-1:0]  rows_eff;
   logic               col_in;
   logic               row_in;
   logic [DATA_W-1:0]  cur;
   logic               accept;
   logic               advance;
   logic               clear_busy;
   logic               mac_ready;
   logic [DATA_W-1:0]  rd_data;
   logic [DATA_W-1:0]  up;
   operands_type       op;

   // plane size clamped: zero becomes one, columns capped at the line store depth
   always_comb begin
      if (columns_ff == '0) begin
         cols_eff = CW'(1);
      end else if (32'(columns_ff) > MAX_COLUMNS) begin
         cols_eff = CW'(MAX_COLUMNS);
      end else begin
         cols_eff = CW'(columns_ff);
      end
      rows_eff = (rows_ff == '0) ? ROWS_W'(1) : rows_ff;
   end

   assign col_in  = col_count_ff < cols_eff;
   assign row_in  = row_count_ff < rows_eff;
   assign cur     = (col_in && row_in) ? req_bus.source_sample : '0;
   assign advance = s1_valid_ff && mac_ready;

   assign req_bus.ready = !clear_busy && (!s1_valid_ff || mac_ready);
   assign accept        = req_bus.valid && req_bus.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         weights_ff <= '0;
         columns_ff <= COLS_W'(1);
         rows_ff    <= ROWS_W'(1);
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_WEIGHT_TL: weights_ff.top_left     <= csr_write_data;
            CSR_WEIGHT_TR: weights_ff.top_right    <= csr_write_data;
            CSR_WEIGHT_BL: weights_ff.bottom_left  <= csr_write_data;
            CSR_WEIGHT_BR: weights_ff.bottom_right <= csr_write_data;
            CSR_COLUMNS:   columns_ff <= csr_write_data[COLS_W-1:0];
            CSR_ROWS:      rows_ff    <= csr_write_data[ROWS_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_count_ff <= '0;
         row_count_ff <= '0;
         s1_valid_ff  <= 1'b0;
      end else begin
         if (req_bus.ready) begin
            s1_valid_ff <= req_bus.valid;
         end
         if (accept) begin
            if (!col_in) begin
               col_count_ff <= '0;
               row_count_ff <= row_in ? row_count_ff + 1'b1 : '0;
            end else begin
               col_count_ff <= col_count_ff + 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         left_ff       <= '0;
         upper_left_ff <= '0;
      end else begin
         if (accept) begin
            left_ff <= cur;
         end
         if (advance) begin
            upper_left_ff <= up;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_accum_ff <= req_bus.accum_in;
         s1_cur_ff   <= cur;
         s1_left_ff  <= (col_count_ff != '0) ? left_ff : '0;
         s1_up_en_ff <= col_in && (row_count_ff != '0);
         s1_ul_en_ff <= (col_count_ff != '0) && (row_count_ff != '0);
         s1_done_ff  <= !col_in && !row_in;
      end
   end

   c2ba_line_store #(
      .MAX_COLUMNS (MAX_COLUMNS)
   ) u_line_store (
      .clock      (clock),
      .reset      (reset),
      .wr_en      (accept && col_in),
      .wr_addr    (col_count_ff[AW-1:0]),
      .wr_data    (cur),
      .rd_en      (accept),
      .rd_addr    (col_count_ff[AW-1:0]),
      .rd_data    (rd_data),
      .clear_busy (clear_busy)
   );

   assign up = s1_up_en_ff ? rd_data : '0;

   always_comb begin
      op.accum      = s1_accum_ff;
      op.cur        = s1_cur_ff;
      op.left       = s1_left_ff;
      op.up         = up;
      op.upper_left = s1_ul_en_ff ? upper_left_ff : '0;
      op.done       = s1_done_ff;
   end

   c2ba_mac u_mac (
      .clock    (clock),
      .reset    (reset),
      .weights  (weights_ff),
      .op       (op),
      .op_valid (s1_valid_ff),
      .op_ready (mac_ready),
      .rsp      (rsp_bus)
   );

endmodule

/* tb/sv/conv2x2_backward_accumulate_tb.sv */
// testbench for conv2x2_backward_accumulate: directed table, random planes, result scoreboard
`timescale 1ns / 1ps

module conv2x2_backward_accumulate_tb import c2ba_pkg::*; ();

   localparam int MAX_COLS     = 1024;
   localparam int RESET_CYCLES = 11;
   localparam int CYCLE_LIMIT  = 500000;
   localparam int HOLD_CYCLES  = 300;
   localparam int RANDOM_BEATS = 800;
   localparam int WIDE_BEATS   = 1030;

   localparam logic signed [63:0] SAT_MAX = 64'sh0000_0000_7FFF_FFFF;
   localparam logic signed [63:0] SAT_MIN = 64'shFFFF_FFFF_8000_0000;

   localparam logic [CSR_IDX_W-1:0] WEIGHT_REGS [4] =
      '{CSR_WEIGHT_TL, CSR_WEIGHT_TR, CSR_WEIGHT_BL, CSR_WEIGHT_BR};

   typedef enum logic {STEP_WRITE, STEP_BEAT} step_kind_type;

   typedef struct packed {
      step_kind_type        kind;
      logic [CSR_IDX_W-1:0] index;
      logic [DATA_W-1:0]    value;
      logic [DATA_W-1:0]    accum;
      logic [DATA_W-1:0]    sample;
      logic                 pinned;
      logic [DATA_W-1:0]    pin_accum;
      logic                 pin_done;
   } script_step_type;

   typedef struct {
      logic [DATA_W-1:0] accum;
      logic              done;
   } grid_result_type;

   // pinned rows: weights zero pass accum through, last row/column drop the
   // sample, saturation at both ends
   localparam int SCRIPT_LEN = 33;
   localparam script_step_type SCRIPT [SCRIPT_LEN] = '{
      '{STEP_BEAT,  CSR_WEIGHT_TL, 32'h0, 32'h7FFFFFFF, 32'h7FFFFFFF, 1'b1, 32'h7FFFFFFF, 1'b0},
      '{STEP_BEAT,  CSR_WEIGHT_TL, 32'h0, 32'h80000000, 32'h80000000, 1'b1, 32'h80000000, 1'b0},
      '{STEP_BEAT,  CSR_WEIGHT_TL, 32'h0, 32'h00000000, 32'h12345678, 1'b1, 32'h00000000, 1'b0},
      '{STEP_BEAT,  CSR_WEIGHT_TL, 32'h0, 32'hFFFFFFFF, 32'h00000000, 1'b1, 32'hFFFFFFFF, 1'b1},
      '{STEP_WRITE, CSR_WEIGHT_TL, 32'h00010000, 32'h0, 32'h0, 1'b0, 32'h0, 1'b0},
      '{STEP_BEAT,  CSR_WEIGHT_TL, 32'h0, 32'h00000005, 32'h00030000, 1'b1, 32'h00030005, 1'b0},
      '{STEP_BEAT,  CSR_WEIGHT_TL, 32'h0, 32'h00000007, 32'h00000063, 1'b1, 32'h00000007, 1'b0},
      '{STEP_BEAT,  CSR_WEIGHT_TL, 32'h0, 32'hFFFFFFFF, 32'h7FFFFFFF, 1'b1, 32'hFFFFFFFF, 1'b0},
      '{STEP_BEAT,  CSR_WEIGHT_TL, 32'h0, 32'h00000000, 32'h7FFFFFFF, 1'b1, 32'h00000000, 1'b1},
      '{STEP_WRITE, CSR_WEIGHT_TL, 32'h7FFFFFFF, 32'h0, 32'h0, 1'b0, 32'h0, 1'b0},
      '{STEP_BEAT,  CSR_WEIGHT_TL, 32'h0, 32'h7FFFFFFF, 32'h7FFFFFFF, 1'b1, 32'h7FFFFFFF, 1'b0},
      '{STEP_WRITE, CSR_WEIGHT_TL, 32'h80000000, 32'h0, 32'h0, 1'b0, 32'h0, 1'b0},
      '{STEP_WRITE, CSR_WEIGHT_TR, 32'h80000000, 32'h0, 32'h0, 1'b0, 32'h0, 1'b0},
      '{STEP_BEAT,  CSR_WEIGHT_TL, 32'h0, 32'h80000000, 32'h00000000, 1'b1, 32'h80000000, 1'b0},
      '{STEP_BEAT,  CSR_WEIGHT_TL, 32'h0, 32'h00001000, 32'h55555555, 1'b0, 32'h0, 1'b0},
      '{STEP_BEAT,  CSR_WEIGHT_TL, 32'h0, 32'h00000000, 32'hAAAAAAAA, 1'b0, 32'h0, 1'b0},
      '{STEP_WRITE, CSR_WEIGHT_TL, 32'h00008000, 32'h0, 32'h0, 1'b0, 32'h0, 1'b0},
      '{STEP_WRITE, CSR_WEIGHT_TR, 32'hFFFF0000, 32'h0, 32'h0, 1'b0, 32'h0, 1'b0},
      '{STEP_WRITE, CSR_WEIGHT_BL, 32'h00020000, 32'h0, 32'h0, 1'b0, 32'h0, 1'b0},
      '{STEP_WRITE, CSR_WEIGHT_BR, 32'h00018000, 32'h0, 32'h0, 1'b0, 32'h0, 1'b0},
      '{STEP_WRITE, CSR_COLUMNS,   32'd2, 32'h0, 32'h0, 1'b0, 32'h0, 1'b0},
      '{STEP_WRITE, CSR_ROWS,      32'd1, 32'h0, 32'h0, 1'b0, 32'h0, 1'b0},
      '{STEP_BEAT,  CSR_WEIGHT_TL, 32'h0, 32'h00100000, 32'h00040000, 1'b0, 32'h0, 1'b0},
      '{STEP_BEAT,  CSR_WEIGHT_TL, 32'h0, 32'hFFF00000, 32'hFFFC8000, 1'b0, 32'h0, 1'b0},
      '{STEP_BEAT,  CSR_WEIGHT_TL, 32'h0, 32'h00000001, 32'h7FFFFFFF, 1'b0, 32'h0, 1'b0},
      '{STEP_BEAT,  CSR_WEIGHT_TL, 32'h0, 32'h00020000, 32'h00011111, 1'b0, 32'h0, 1'b0},
      // width shrunk to zero mid-plane: the next position closes the plane
      '{STEP_WRITE, CSR_COLUMNS,   32'd0, 32'h0, 32'h0, 1'b0, 32'h0, 1'b0},
      '{STEP_BEAT,  CSR_WEIGHT_TL, 32'h0, 32'h00000100, 32'h00050000, 1'b0, 32'h0, 1'b0},
      '{STEP_WRITE, CSR_ROWS,      32'd0, 32'h0, 32'h0, 1'b0, 32'h0, 1'b0},
      '{STEP_BEAT,  CSR_WEIGHT_TL, 32'h0, 32'h00000000, 32'hFFFF8000, 1'b0, 32'h0, 1'b0},
      '{STEP_BEAT,  CSR_WEIGHT_TL, 32'h0, 32'h00010000, 32'h00007000, 1'b0, 32'h0, 1'b0},
      '{STEP_BEAT,  CSR_WEIGHT_TL, 32'h0, 32'hFFFF0000, 32'h00003000, 1'b0, 32'h0, 1'b0},
      '{STEP_BEAT,  CSR_WEIGHT_TL, 32'h0, 32'h00000042, 32'h00002000, 1'b0, 32'h0, 1'b0}
   };

   logic                 clock = 1'b0;
   logic                 reset;
   logic                 csr_write_enable;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [DATA_W-1:0]    csr_write_data;

   c2ba_req_if req_bus ();
   c2ba_rsp_if rsp_bus ();

   conv2x2_backward_accumulate #(.MAX_COLUMNS(MAX_COLS)) uut (
      .clock            (clock),
      .reset            (reset),
      .req_bus          (req_bus),
      .rsp_bus          (rsp_bus),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // shadow of the block's registers and neighbour state
   logic signed [DATA_W-1:0] weight_tl = '0;
   logic signed [DATA_W-1:0] weight_tr = '0;
   logic signed [DATA_W-1:0] weight_bl = '0;
   logic signed [DATA_W-1:0] weight_br = '0;
   logic [COLS_W-1:0]        plane_columns = 11'd1;
   logic [ROWS_W-1:0]        plane_rows = 16'd1;
   logic signed [DATA_W-1:0] line_store [MAX_COLS];
   logic signed [DATA_W-1:0] left_q = '0;
   logic signed [DATA_W-1:0] upper_left_q = '0;
   logic [COLS_W-1:0]        col_pos = '0;
   logic [ROWS_W:0]          row_pos = '0;

   grid_result_type pending_positions [$];
   int              mismatch_count = 0;
   int              cycle_count = 0;
   int              beats_sent = 0;
   int              results_seen = 0;
   bit              last_done = 1'b0;
   bit              burst_mode = 1'b0;
   bit              rx_burst = 1'b0;
   bit              hold_output = 1'b0;

   initial begin
      foreach (line_store[i]) line_store[i] = '0;
   end

   function automatic logic signed [63:0] scaled_product(input logic signed [DATA_W-1:0] weight,
                                                         input logic signed [DATA_W-1:0] value);
      logic signed [63:0] prod;
      prod = weight * value;
      return prod >>> FRAC_W;
   endfunction

   // one grid position in raster order; updates the neighbour state
   function automatic grid_result_type accumulate_position(
         input logic signed [DATA_W-1:0] accum,
         input logic signed [DATA_W-1:0] sample);
      int unsigned              cols_eff;
      int unsigned              rows_eff;
      logic                     col_in;
      logic                     row_in;
      logic signed [DATA_W-1:0] cur;
      logic signed [DATA_W-1:0] left;
      logic signed [DATA_W-1:0] up;
      logic signed [DATA_W-1:0] upleft;
      logic signed [63:0]       total;
      grid_result_type          res;
      cols_eff = plane_columns;
      if (cols_eff < 1) cols_eff = 1;
      if (cols_eff > MAX_COLS) cols_eff = MAX_COLS;
      rows_eff = plane_rows;
      if (rows_eff < 1) rows_eff = 1;
      col_in = col_pos < cols_eff;
      row_in = row_pos < rows_eff;
      cur    = (col_in && row_in) ? sample : '0;
      up     = (col_in && row_pos != 0) ? line_store[col_pos] : '0;
      left   = (col_pos != 0) ? left_q : '0;
      upleft = (col_pos != 0 && row_pos != 0) ? upper_left_q : '0;
      total = accum;
      total = total + scaled_product(weight_tl, cur) + scaled_product(weight_tr, left)
            + scaled_product(weight_bl, up) + scaled_product(weight_br, upleft);
      if (total > SAT_MAX) total = SAT_MAX;
      else if (total < SAT_MIN) total = SAT_MIN;
      res.accum = total[DATA_W-1:0];
      res.done  = !col_in && !row_in;
      upper_left_q = up;
      left_q = cur;
      if (col_in) line_store[col_pos] = cur;
      if (!col_in) begin
         col_pos = '0;
         row_pos = row_in ? row_pos + 1'b1 : '0;
      end else begin
         col_pos = col_pos + 1'b1;
      end
      return res;
   endfunction

   // mix of full range, extremes and small magnitudes that rarely saturate
   function automatic logic [DATA_W-1:0] random_q16();
      logic [DATA_W-1:0] r;
      r = $urandom;
      case ($urandom_range(0, 5))
         0: return r;
         1: return $urandom_range(0, 1) ? 32'h7FFFFFFF : 32'h80000000;
         2, 3: return {{14{r[17]}}, r[17:0]};
         default: return {{8{r[23]}}, r[23:0]};
      endcase
   endfunction

   task automatic write_register(input logic [CSR_IDX_W-1:0] index,
                                 input logic [DATA_W-1:0] value);
      req_bus.valid <= 1'b0;
      while (pending_positions.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= index;
      csr_write_data   <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      case (index)
         CSR_WEIGHT_TL: weight_tl = value;
         CSR_WEIGHT_TR: weight_tr = value;
         CSR_WEIGHT_BL: weight_bl = value;
         CSR_WEIGHT_BR: weight_br = value;
         CSR_COLUMNS:   plane_columns = value[COLS_W-1:0];
         CSR_ROWS:      plane_rows = value[ROWS_W-1:0];
         default: ;
      endcase
   endtask

   // valid stays high across back-to-back beats
   task automatic send_beat(input logic [DATA_W-1:0] accum, input logic [DATA_W-1:0] sample,
                            input logic pinned, input logic [DATA_W-1:0] pin_accum,
                            input logic pin_done);
      int              gap;
      grid_result_type predicted;
      gap = burst_mode ? 0 : $urandom_range(0, 18);
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid         <= 1'b1;
      req_bus.accum_in      <= accum;
      req_bus.source_sample <= sample;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      predicted = accumulate_position(accum, sample);
      last_done = predicted.done;
      if (pinned) begin
         predicted.accum = pin_accum;
         predicted.done  = pin_done;
      end
      pending_positions.push_back(predicted);
      beats_sent++;
   endtask

   function automatic void check_result(input logic [DATA_W-1:0] accum, input logic done);
      grid_result_type want;
      if (pending_positions.size() == 0) begin
         $display("%0t: unexpected beat, accum_out %h plane_done %b", $time, accum, done);
         mismatch_count++;
         return;
      end
      want = pending_positions.pop_front();
      if (accum !== want.accum) begin
         $display("%0t: accum_out expected %h actual %h", $time, want.accum, accum);
         mismatch_count++;
      end
      if (done !== want.done) begin
         $display("%0t: plane_done expected %b actual %b", $time, want.done, done);
         mismatch_count++;
      end
   endfunction

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // result side: random stalls, one long hold-off on request
   initial begin
      int stall;
      rsp_bus.ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (hold_output) begin
            rsp_bus.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_output = 1'b0;
         end
         stall = rx_burst ? 0 : $urandom_range(0, 18);
         if (stall > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         @(posedge clock);
         while (!rsp_bus.valid) @(posedge clock);
         check_result(rsp_bus.accum_out, rsp_bus.plane_done);
         results_seen++;
         if (results_seen % 64 == 0) rx_burst = ($urandom_range(0, 3) == 0);
      end
   end

   initial begin
      int phase;
      int sel;
      int cols_val;
      int rows_val;
      int n;
      bit partial;
      reset                 <= 1'b1;
      req_bus.valid         <= 1'b0;
      req_bus.accum_in      <= '0;
      req_bus.source_sample <= '0;
      csr_write_enable      <= 1'b0;
      csr_index             <= CSR_WEIGHT_TL;
      csr_write_data        <= '0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < SCRIPT_LEN; i++) begin
         if (SCRIPT[i].kind == STEP_WRITE)
            write_register(SCRIPT[i].index, SCRIPT[i].value);
         else
            send_beat(SCRIPT[i].accum, SCRIPT[i].sample, SCRIPT[i].pinned,
                      SCRIPT[i].pin_accum, SCRIPT[i].pin_done);
      end

      // random planes, mostly small; partial planes leave the counters
      // mid-plane for the next size change
      beats_sent = 0;
      phase = 0;
      while (beats_sent < RANDOM_BEATS) begin
         sel      = $urandom_range(0, 19);
         partial  = ($urandom_range(0, 4) == 0);
         cols_val = $urandom_range(1, 6);
         rows_val = $urandom_range(1, 4);
         if (sel >= 14 && sel < 17) begin
            cols_val = $urandom_range(7, 40);
         end else if (sel == 17) begin
            if ($urandom_range(0, 1)) cols_val = 0;
            else rows_val = 0;
         end else if (sel == 18) begin
            cols_val = MAX_COLS;
            partial  = 1'b1;
         end else if (sel == 19) begin
            rows_val = 65535;
            partial  = 1'b1;
         end
         if (phase == 3) begin
            cols_val = 8;
            rows_val = 4;
            partial  = 1'b0;
         end
         burst_mode = (phase == 3) || ($urandom_range(0, 3) == 0);
         foreach (WEIGHT_REGS[k])
            if (phase == 0 || $urandom_range(0, 3) != 0) write_register(WEIGHT_REGS[k], random_q16());
         write_register(CSR_COLUMNS, cols_val);
         write_register(CSR_ROWS, rows_val);
         // output held off while a whole plane is offered back to back
         if (phase == 3) hold_output = 1'b1;
         if (partial) begin
            n = $urandom_range(1, 24);
            repeat (n) send_beat(random_q16(), random_q16(), 1'b0, '0, 1'b0);
         end else begin
            do send_beat(random_q16(), random_q16(), 1'b0, '0, 1'b0); while (!last_done);
         end
         phase++;
      end

      // oversized width clamps to the line store depth; the second row is cut
      // short by a width change
      burst_mode = ($urandom_range(0, 1) == 0);
      foreach (WEIGHT_REGS[k]) write_register(WEIGHT_REGS[k], random_q16());
      write_register(CSR_COLUMNS, 32'd2047);
      write_register(CSR_ROWS, 32'd1);
      repeat (WIDE_BEATS) send_beat(random_q16(), random_q16(), 1'b0, '0, 1'b0);
      write_register(CSR_COLUMNS, 32'd3);
      do send_beat(random_q16(), random_q16(), 1'b0, '0, 1'b0); while (!last_done);

      req_bus.valid <= 1'b0;
      while (pending_positions.size() != 0) @(posedge clock);
      repeat (12) @(posedge clock);
      if (mismatch_count == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule
